// ----- src/rhes_pkg.sv -----
package rhes_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AccW     = 36;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_INTERVAL,
    REG_PEAK_FREQUENCY,
    REG_AMPLITUDE,
    REG_ZERO_OFFSET_TIME,
    REG_APEX_POSITION,
    REG_SLOWNESS,
    REG_MULTIPLE_GAIN
  } reg_idx_e;

  localparam logic [29:0] KPi    = 30'd843314857;
  localparam logic [28:0] KLog2e = 29'd387270501;
  localparam logic [27:0] KLn2   = 28'd186065280;
  localparam logic [43:0] TimeCap = {44{1'b1}};

  localparam logic [30:0]        RstSampleInterval = 31'd1073742;
  localparam logic [15:0]        RstPeakFrequency  = 16'd7680;
  localparam logic signed [31:0] RstAmplitude      = 32'sd16777216;
  localparam logic [30:0]        RstZeroOffsetTime = 31'd0;
  localparam logic signed [31:0] RstApexPosition   = 32'sd0;
  localparam logic [30:0]        RstSlowness       = 31'd134218;
  localparam logic signed [31:0] RstMultipleGain   = 32'sd0;

  typedef struct packed {
    logic [9:0]         trace_index;
    logic signed [31:0] trace_offset;
    logic [11:0]        sample_index;
    logic signed [31:0] prior_value;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]         trace_number;
    logic [11:0]        sample_number;
    logic signed [31:0] new_value;
  } out_beat_t;

  typedef struct packed {
    logic [30:0]        sample_interval;
    logic [15:0]        peak_frequency;
    logic signed [31:0] amplitude;
    logic [30:0]        zero_offset_time;
    logic signed [31:0] apex_position;
    logic [30:0]        slowness;
    logic signed [31:0] multiple_gain;
  } cfg_t;

  typedef struct packed {
    logic [9:0]              tag;
    logic [11:0]             sidx;
    logic signed [AccW-1:0]  acc;
    logic signed [31:0]      amp;
    logic [43:0]             horiz;
    logic [42:0]             now;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/rhes_in_if.sv -----
interface rhes_in_if;
  logic               valid;
  logic               ready;
  rhes_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/rhes_out_if.sv -----
interface rhes_out_if;
  logic                valid;
  logic                ready;
  rhes_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/rhes_front.sv -----
module rhes_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rhes_pkg::cfg_t     cfg_i,
  input  logic               vld_i,
  input  rhes_pkg::in_beat_t beat_i,
  output logic               vld_o,
  output rhes_pkg::ctx_t     ctx_o
);

  logic [2:0]         vld_q;
  logic [9:0]         tag_q [2];
  logic [11:0]        sidx_q [2];
  logic signed [31:0] prior_q [2];
  logic [42:0]        now_q [2];
  logic [31:0]        dmag_q;
  logic [62:0]        hp_q;
  logic signed [32:0] diff;
  logic [54:0]        hs;
  rhes_pkg::ctx_t     ctx_q;

  assign diff = 33'(beat_i.trace_offset) - 33'(cfg_i.apex_position);
  assign hs   = hp_q[62:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q     <= diff[32] ? 32'(-diff) : 32'(diff);
      now_q[0]   <= 43'(beat_i.sample_index) * 43'(cfg_i.sample_interval);
      tag_q[0]   <= beat_i.trace_index;
      sidx_q[0]  <= beat_i.sample_index;
      prior_q[0] <= beat_i.prior_value;
      hp_q       <= 63'(dmag_q) * 63'(cfg_i.slowness);
      now_q[1]   <= now_q[0];
      tag_q[1]   <= tag_q[0];
      sidx_q[1]  <= sidx_q[0];
      prior_q[1] <= prior_q[0];
      ctx_q.tag   <= tag_q[1];
      ctx_q.sidx  <= sidx_q[1];
      ctx_q.acc   <= rhes_pkg::AccW'(prior_q[1]);
      ctx_q.amp   <= cfg_i.amplitude;
      ctx_q.horiz <= (|hs[54:44]) ? rhes_pkg::TimeCap : hs[43:0];
      ctx_q.now   <= now_q[1];
    end
  end

  assign vld_o = vld_q[2];
  assign ctx_o = ctx_q;

endmodule

// ----- src/rhes_cell.sv -----
module rhes_cell #(
  parameter int unsigned MULT = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rhes_pkg::cfg_t cfg_i,
  input  logic           vld_i,
  input  rhes_pkg::ctx_t ctx_i,
  output logic           vld_o,
  output rhes_pkg::ctx_t ctx_o
);

  localparam int unsigned SqSteps  = 32;
  localparam int unsigned TlSteps  = 13;
  localparam int unsigned StSqEnd  = 3 + SqSteps;
  localparam int unsigned StE      = StSqEnd + 1;
  localparam int unsigned StJ      = StE + 5;
  localparam int unsigned StK      = StJ + 2 * TlSteps + 1;
  localparam int unsigned StL      = StK + 1;
  localparam int unsigned StM      = StL + 1;
  localparam int unsigned Depth    = StM + 2;
  localparam logic [5:0]  MultC    = 6'(MULT);

  logic [Depth-1:0] vld_q;
  rhes_pkg::ctx_t   ctx_q [Depth];
  rhes_pkg::ctx_t   ctx_n;

  // hypotenuse front
  logic [36:0] vert_q;
  logic [30:0] a_q, b_q;
  logic [3:0]  kb_q, kc_q;
  logic [61:0] aa_q, bb_q;
  logic [43:0] vert_w, span;
  logic [3:0]  k_d;

  // square root steps
  logic [63:0] rad_q  [SqSteps];
  logic [33:0] rem_q  [SqSteps];
  logic [31:0] root_q [SqSteps+1];
  logic [3:0]  sk_q   [SqSteps+1];

  // wavelet argument
  logic [44:0]        tau_w;
  logic signed [46:0] d_q;
  logic [45:0]        mag;
  logic [61:0]        qf_q;
  logic [30:0]        w_q;
  logic               zg_q, zh_q, zi_q;
  logic [33:0]        xh_q, xi_q;
  logic [34:0]        y_q;

  // series for exp
  logic [30:0]        term_q [TlSteps+1];
  logic signed [31:0] sum_q  [TlSteps+1];
  logic [27:0]        z_q    [TlSteps];
  logic [6:0]         n_q    [TlSteps+1];
  logic [33:0]        x_q    [TlSteps+1];
  logic               zero_q [TlSteps+1];
  logic [58:0]        prod_q [1:TlSteps];
  logic signed [31:0] psum_q [1:TlSteps];
  logic [27:0]        mz_q   [1:TlSteps-1];
  logic [6:0]         mn_q   [1:TlSteps];
  logic [33:0]        mx_q   [1:TlSteps];
  logic               mzero_q [1:TlSteps];

  // tail
  logic signed [31:0] tot;
  logic [7:0]         sh;
  logic [28:0]        e_q;
  logic signed [63:0] gp_q;
  logic [33:0]        xk_q;
  logic               zk_q;
  logic signed [35:0] onemx;
  logic signed [65:0] rp;
  logic signed [37:0] r_q;
  logic signed [31:0] anx_q, amx_q;
  logic signed [69:0] cp;
  logic signed [33:0] c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], vld_i};
    end
  end

  always_comb begin
    ctx_n     = ctx_q[StM];
    ctx_n.acc = ctx_q[StM].acc + rhes_pkg::AccW'(c_q);
    ctx_n.amp = amx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int s = 1; s < Depth - 1; s++) begin
        ctx_q[s] <= ctx_q[s-1];
      end
      ctx_q[Depth-1] <= ctx_n;
    end
  end

  always_comb begin
    vert_w = 44'(vert_q);
    span   = vert_w | ctx_q[0].horiz;
    k_d    = '0;
    for (int b = 0; b < 13; b++) begin
      if (span[31+b]) begin
        k_d = 4'(b + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vert_q    <= 37'(cfg_i.zero_offset_time) * 37'(MultC);
      a_q       <= 31'(vert_w >> k_d);
      b_q       <= 31'(ctx_q[0].horiz >> k_d);
      kb_q      <= k_d;
      aa_q      <= 62'(a_q) * 62'(a_q);
      bb_q      <= 62'(b_q) * 62'(b_q);
      kc_q      <= kb_q;
      rad_q[0]  <= {1'b0, 63'(aa_q) + 63'(bb_q)};
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      sk_q[0]   <= kc_q;
    end
  end

  for (genvar j = 1; j <= SqSteps; j++) begin : g_sq
    logic [35:0] rr, tt;
    assign rr = {rem_q[j-1], rad_q[j-1][63:62]};
    assign tt = {2'b00, root_q[j-1], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sk_q[j]   <= sk_q[j-1];
        root_q[j] <= {root_q[j-1][30:0], rr >= tt};
      end
    end
    if (j < SqSteps) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[j] <= {rad_q[j-1][61:0], 2'b00};
          rem_q[j] <= (rr >= tt) ? 34'(rr - tt) : rr[33:0];
        end
      end
    end
  end

  assign tau_w = 45'(root_q[SqSteps]) << sk_q[SqSteps];
  assign mag   = d_q[46] ? 46'(-d_q) : 46'(d_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q  <= $signed({4'b0, ctx_q[StE-1].now}) - $signed({2'b0, tau_w});
      qf_q <= 62'(mag) * 62'(cfg_i.peak_frequency);
      zg_q <= |qf_q[61:37];
      w_q  <= 31'((59'(qf_q[36:8]) * 59'(rhes_pkg::KPi)) >> 28);
      xh_q <= 34'((62'(w_q) * 62'(w_q)) >> 28);
      zh_q <= zg_q;
      y_q  <= 35'((63'(xh_q) * 63'(rhes_pkg::KLog2e)) >> 28);
      xi_q <= xh_q;
      zi_q <= zh_q;
      term_q[0] <= 31'd1 << 30;
      sum_q[0]  <= '0;
      z_q[0]    <= 28'((56'(y_q[27:0]) * 56'(rhes_pkg::KLn2)) >> 28);
      n_q[0]    <= y_q[34:28];
      x_q[0]    <= xi_q;
      zero_q[0] <= zi_q;
    end
  end

  for (genvar t = 1; t <= TlSteps; t++) begin : g_tl
    localparam logic [36:0] Num   = (37'd1 << 35) + 37'(t) - 37'd1;
    localparam logic [35:0] Recip = 36'(Num / 37'(t));
    localparam bit          Sub   = ((t - 1) % 2) == 1;
    logic signed [31:0] tsig;
    logic [66:0]        qp;
    assign tsig = $signed({1'b0, term_q[t-1]});
    assign qp   = 67'(prod_q[t][58:28]) * 67'(Recip);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[t]  <= 59'(term_q[t-1]) * 59'(z_q[t-1]);
        psum_q[t]  <= Sub ? sum_q[t-1] - tsig : sum_q[t-1] + tsig;
        mn_q[t]    <= n_q[t-1];
        mx_q[t]    <= x_q[t-1];
        mzero_q[t] <= zero_q[t-1];
        term_q[t]  <= 31'(qp >> 35);
        sum_q[t]   <= psum_q[t];
        n_q[t]     <= mn_q[t];
        x_q[t]     <= mx_q[t];
        zero_q[t]  <= mzero_q[t];
      end
    end
    if (t < TlSteps) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mz_q[t] <= z_q[t-1];
          z_q[t]  <= mz_q[t];
        end
      end
    end
  end

  assign tot   = sum_q[TlSteps] - $signed({1'b0, term_q[TlSteps]});
  assign sh    = {1'b0, n_q[TlSteps]} + 8'd2;
  assign onemx = $signed(36'd268435456) - $signed({1'b0, xk_q, 1'b0});
  assign rp    = 66'(onemx) * 66'($signed({1'b0, e_q}));
  assign cp    = 70'(ctx_q[StL].amp) * 70'(r_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q   <= (n_q[TlSteps] > 7'd61) ? '0 : 29'(tot[30:0] >> sh);
      gp_q  <= 64'(ctx_q[StK-1].amp) * 64'(cfg_i.multiple_gain);
      xk_q  <= x_q[TlSteps];
      zk_q  <= zero_q[TlSteps];
      r_q   <= zk_q ? '0 : 38'(rp >>> 28);
      anx_q <= rhes_pkg::sat32(64'(gp_q >>> 24));
      c_q   <= 34'(cp >>> 36);
      amx_q <= anx_q;
    end
  end

  assign vld_o = vld_q[Depth-1];
  assign ctx_o = ctx_q[Depth-1];

endmodule

// ----- src/ricker_hyperbolic_event_synth_core.sv -----
// Hyperbolic Ricker event synthesizer.
// Input channel in_i carries one trace sample per beat: trace index, trace
// offset, sample index and the value accumulated so far. Output channel out_o
// returns the trace and sample numbers with the new saturated value.
// Both channels move a beat on a rising edge where valid and ready are high.
// The configuration port writes register cfg_idx_i with cfg_data_i whenever
// cfg_we_i is high; write only while no beat is in flight.
// A front stage forms the offset time and the sample time, then a
// row of NUM_MULTIPLES cells adds one multiple each; a cell is 72 stages deep
// (a 32 step square root and a 13 term exp series, all pipelined).
// One beat per cycle while the output buffer is not full.
// A two entry output buffer keeps in_i ready while a result waits; when the
// receiver stalls and the buffer fills, the whole pipeline holds and in_i
// ready drops until out_o drains.
// Reset empties the pipeline and the buffer and loads the register defaults.
module ricker_hyperbolic_event_synth_core #(
  parameter int unsigned NUM_MULTIPLES = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rhes_in_if.sink                        in_i,
  rhes_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [rhes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rhes_pkg::CfgDataW-1:0]  cfg_data_i
);

  rhes_pkg::cfg_t      cfg_q;
  rhes_pkg::ctx_t      ch_ctx [NUM_MULTIPLES+1];
  logic [NUM_MULTIPLES:0] ch_vld;
  logic                en;
  logic                push, pop;
  rhes_pkg::out_beat_t buf_q [2];
  rhes_pkg::out_beat_t wdata;
  logic [1:0]          cnt_q;
  logic                wr_q, rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval  <= rhes_pkg::RstSampleInterval;
      cfg_q.peak_frequency   <= rhes_pkg::RstPeakFrequency;
      cfg_q.amplitude        <= rhes_pkg::RstAmplitude;
      cfg_q.zero_offset_time <= rhes_pkg::RstZeroOffsetTime;
      cfg_q.apex_position    <= rhes_pkg::RstApexPosition;
      cfg_q.slowness         <= rhes_pkg::RstSlowness;
      cfg_q.multiple_gain    <= rhes_pkg::RstMultipleGain;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rhes_pkg::REG_SAMPLE_INTERVAL:  cfg_q.sample_interval  <= cfg_data_i[30:0];
        rhes_pkg::REG_PEAK_FREQUENCY:   cfg_q.peak_frequency   <= cfg_data_i[15:0];
        rhes_pkg::REG_AMPLITUDE:        cfg_q.amplitude        <= cfg_data_i;
        rhes_pkg::REG_ZERO_OFFSET_TIME: cfg_q.zero_offset_time <= cfg_data_i[30:0];
        rhes_pkg::REG_APEX_POSITION:    cfg_q.apex_position    <= cfg_data_i;
        rhes_pkg::REG_SLOWNESS:         cfg_q.slowness         <= cfg_data_i[30:0];
        rhes_pkg::REG_MULTIPLE_GAIN:    cfg_q.multiple_gain    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  rhes_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .vld_i  (in_i.valid),
    .beat_i (in_i.data),
    .vld_o  (ch_vld[0]),
    .ctx_o  (ch_ctx[0])
  );

  for (genvar g = 0; g < NUM_MULTIPLES; g++) begin : g_cell
    rhes_cell #(
      .MULT (g + 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cfg_i  (cfg_q),
      .vld_i  (ch_vld[g]),
      .ctx_i  (ch_ctx[g]),
      .vld_o  (ch_vld[g+1]),
      .ctx_o  (ch_ctx[g+1])
    );
  end

  always_comb begin
    wdata.trace_number  = ch_ctx[NUM_MULTIPLES].tag;
    wdata.sample_number = ch_ctx[NUM_MULTIPLES].sidx;
    wdata.new_value     = rhes_pkg::sat32(64'(ch_ctx[NUM_MULTIPLES].acc));
  end

  assign push = en & ch_vld[NUM_MULTIPLES];
  assign pop  = (cnt_q != 2'd0) & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= wdata;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = buf_q[rd_q];

endmodule
